// ===== sv/hre_pkg.sv =====
// ----------------------------------------------------------------------------
// hre_pkg
// shared widths, constants and types of the heat recovery efficiency filter
// ----------------------------------------------------------------------------
package hre_pkg;

	localparam int TEMP_W    = 12;
	localparam int DIFF_W    = TEMP_W + 1;
	localparam int MAG_W     = TEMP_W;
	localparam int EFF_W     = 15;
	localparam int EFF_FULL  = 25600;
	localparam int PROD_W    = $clog2((2 ** MAG_W - 1) * EFF_FULL + 1);
	localparam int WIN_LEN   = 16;
	localparam int WIN_AW    = $clog2(WIN_LEN);
	localparam int SUM_W     = $clog2(WIN_LEN * EFF_FULL + 1);
	localparam int DIV_STEPS = EFF_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	localparam logic [EFF_W-1:0] EFF_FULL_V = EFF_W'(EFF_FULL);

	typedef enum logic [1:0] {
		DM_ZERO,
		DM_FULL,
		DM_CALC
	} div_mode_t;

	typedef enum logic [1:0] {
		WIN_IDLE,
		WIN_FILL,
		WIN_READ,
		WIN_PUSH
	} win_op_t;

	typedef struct packed {
		win_op_t             op;
		logic [WIN_AW-1:0]   addr;
	} win_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_START,
		ST_DIV,
		ST_FILL,
		ST_READ,
		ST_PUSH,
		ST_OUT
	} state_t;

endpackage

// ===== sv/hre_in_if.sv =====
// ----------------------------------------------------------------------------
// hre_in_if
// sensor channel: four temperatures and the defrost flag
// ----------------------------------------------------------------------------
interface hre_in_if import hre_pkg::*; ;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] supply_air_temp;
	logic signed [TEMP_W-1:0] outdoor_air_temp;
	logic signed [TEMP_W-1:0] room_air_temp;
	logic signed [TEMP_W-1:0] exhaust_air_temp;
	logic                     defrost_active;

	modport source (
		output valid, supply_air_temp, outdoor_air_temp, room_air_temp,
		       exhaust_air_temp, defrost_active,
		input  ready
	);

	modport sink (
		input  valid, supply_air_temp, outdoor_air_temp, room_air_temp,
		       exhaust_air_temp, defrost_active,
		output ready
	);
endinterface

// ===== sv/hre_out_if.sv =====
// ----------------------------------------------------------------------------
// hre_out_if
// result channel: fresh and filtered efficiencies, zero span flag
// ----------------------------------------------------------------------------
interface hre_out_if import hre_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [EFF_W-1:0] supply_efficiency;
	logic [EFF_W-1:0] exhaust_efficiency;
	logic [EFF_W-1:0] in_filtered;
	logic [EFF_W-1:0] out_filtered;
	logic             zero_span;

	modport source (
		output valid, supply_efficiency, exhaust_efficiency, in_filtered, out_filtered,
		       zero_span,
		input  ready
	);

	modport sink (
		input  valid, supply_efficiency, exhaust_efficiency, in_filtered, out_filtered,
		       zero_span,
		output ready
	);
endinterface

// ===== sv/hre_div.sv =====
// ----------------------------------------------------------------------------
// hre_div
// bit-serial ratio unit: |num| * 25600 / |den|, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hre_div import hre_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIFF_W-1:0] num,
	input  logic signed [DIFF_W-1:0] den,
	output logic                     done,
	output logic [EFF_W-1:0]         quot
);

	logic [MAG_W-1:0]  an;
	logic [MAG_W-1:0]  ad;
	logic [PROD_W-1:0] prod;
	div_mode_t         mode;

	logic              busy_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              done_q;
	div_mode_t         mode_q;
	logic [MAG_W-1:0]  ad_q;
	logic [MAG_W-1:0]  rem_q;
	logic [EFF_W-1:0]  shr_q;

	logic [MAG_W:0]    trial;
	logic [MAG_W:0]    trial_sub;
	logic              ge;

	always_comb begin
		an   = num[DIFF_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];
		ad   = den[DIFF_W-1] ? MAG_W'(-den) : den[MAG_W-1:0];
		prod = PROD_W'(an) * PROD_W'(EFF_FULL);
		if (den == '0) begin
			mode = (num != '0 && !num[DIFF_W-1]) ? DM_FULL : DM_ZERO;
		end else if (num == '0 || num[DIFF_W-1] != den[DIFF_W-1]) begin
			mode = DM_ZERO;
		end else if (an >= ad) begin
			mode = DM_FULL;
		end else begin
			mode = DM_CALC;
		end
	end

	assign trial     = {rem_q, shr_q[EFF_W-1]};
	assign trial_sub = trial - {1'b0, ad_q};
	assign ge        = trial >= {1'b0, ad_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= mode;
			ad_q   <= ad;
			rem_q  <= MAG_W'(prod >> EFF_W);
			shr_q  <= prod[EFF_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];
			shr_q <= {shr_q[EFF_W-2:0], ge};
		end
	end

	always_comb begin
		unique case (mode_q)
			DM_FULL: quot = EFF_FULL_V;
			DM_CALC: quot = shr_q;
			default: quot = '0;
		endcase
	end

	assign done = done_q;

endmodule

// ===== sv/hre_window.sv =====
// ----------------------------------------------------------------------------
// hre_window
// moving average window: sample store, running sum and average
// ----------------------------------------------------------------------------
module hre_window import hre_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  win_ctl_t         ctl,
	input  logic [EFF_W-1:0] sample,
	output logic [EFF_W-1:0] avg
);

	logic [EFF_W-1:0] mem_q [WIN_LEN];
	logic [EFF_W-1:0] rd_q;
	logic [SUM_W-1:0] sum_q;

	always_ff @(posedge clk) begin
		if (ctl.op == WIN_FILL || ctl.op == WIN_PUSH) begin
			mem_q[ctl.addr] <= sample;
		end
		if (ctl.op == WIN_READ) begin
			rd_q <= mem_q[ctl.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else begin
			case (ctl.op)
				WIN_FILL: sum_q <= SUM_W'(sample) << WIN_AW;
				WIN_PUSH: sum_q <= sum_q - SUM_W'(rd_q) + SUM_W'(sample);
				default:  sum_q <= sum_q;
			endcase
		end
	end

	assign avg = EFF_W'(sum_q >> WIN_AW);

endmodule

// ===== sv/heat_recovery_efficiency_filter_top.sv =====
// ----------------------------------------------------------------------------
// heat_recovery_efficiency_filter_top
// supply and exhaust efficiency with moving average filters
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  sensor    in   valid/ready    four 12 bit temperatures, defrost flag
//  report    out  valid/ready    two efficiencies, two averages, zero span
//
//  one transaction at a time; the first transaction after reset
//  sweeps both 16-entry windows
//  the 15-step bit-serial ratio units set the bulk of the latency
//  after reset both filters read zero until the first transaction is taken
//  a result waiting in the output register holds the next one in ST_OUT;
//  a new transaction is taken while that result is still waiting
// ----------------------------------------------------------------------------
module heat_recovery_efficiency_filter_top import hre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	hre_in_if.sink    sensor,
	hre_out_if.source report
);

	state_t state_q;
	state_t state_d;

	logic signed [TEMP_W-1:0] supply_q;
	logic signed [TEMP_W-1:0] outdoor_q;
	logic signed [TEMP_W-1:0] room_q;
	logic signed [TEMP_W-1:0] exhaust_q;
	logic                     defrost_q;
	logic signed [DIFF_W-1:0] num_in_q;
	logic signed [DIFF_W-1:0] num_out_q;
	logic signed [DIFF_W-1:0] den_q;

	logic [WIN_AW-1:0] ring_q;
	logic [WIN_AW-1:0] cnt_q;
	logic              started_q;

	logic              out_valid_q;
	logic [EFF_W-1:0]  in_eff_q;
	logic [EFF_W-1:0]  out_eff_q;
	logic [EFF_W-1:0]  in_filt_q;
	logic [EFF_W-1:0]  out_filt_q;
	logic              zero_span_q;

	logic              accept;
	logic              div_start;
	logic              done_in;
	logic              done_out;
	logic [EFF_W-1:0]  quot_in;
	logic [EFF_W-1:0]  quot_out;
	logic [EFF_W-1:0]  avg_in;
	logic [EFF_W-1:0]  avg_out;
	logic [EFF_W-1:0]  smp_in;
	logic [EFF_W-1:0]  smp_out;
	win_ctl_t          wctl;
	logic              out_load;

	assign accept = sensor.valid && sensor.ready;

	hre_div u_div_in (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_in_q),
		.den    (den_q),
		.done   (done_in),
		.quot   (quot_in)
	);

	hre_div u_div_out (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_out_q),
		.den    (den_q),
		.done   (done_out),
		.quot   (quot_out)
	);

	// during defrost a push puts the previous average back into the window
	assign smp_in  = (state_q == ST_PUSH && defrost_q) ? avg_in  : quot_in;
	assign smp_out = (state_q == ST_PUSH && defrost_q) ? avg_out : quot_out;

	hre_window u_win_in (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wctl),
		.sample (smp_in),
		.avg    (avg_in)
	);

	hre_window u_win_out (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wctl),
		.sample (smp_out),
		.avg    (avg_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sensor.ready = 1'b0;
		div_start    = 1'b0;
		wctl.op      = WIN_IDLE;
		wctl.addr    = ring_q;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sensor.ready = 1'b1;
				if (sensor.valid) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				state_d = ST_START;
			end
			ST_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (done_in) begin
					state_d = started_q ? ST_READ : ST_FILL;
				end
			end
			ST_FILL: begin
				wctl.op   = WIN_FILL;
				wctl.addr = cnt_q;
				if (cnt_q == WIN_AW'(WIN_LEN - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_READ: begin
				wctl.op = WIN_READ;
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				wctl.op = WIN_PUSH;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || report.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			supply_q  <= sensor.supply_air_temp;
			outdoor_q <= sensor.outdoor_air_temp;
			room_q    <= sensor.room_air_temp;
			exhaust_q <= sensor.exhaust_air_temp;
			defrost_q <= sensor.defrost_active;
		end
		if (state_q == ST_DIFF) begin
			num_in_q  <= DIFF_W'(supply_q) - DIFF_W'(outdoor_q);
			num_out_q <= DIFF_W'(room_q) - DIFF_W'(exhaust_q);
			den_q     <= DIFF_W'(room_q) - DIFF_W'(outdoor_q);
		end
		if (out_load) begin
			in_eff_q    <= quot_in;
			out_eff_q   <= quot_out;
			in_filt_q   <= avg_in;
			out_filt_q  <= avg_out;
			zero_span_q <= (den_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q      <= '0;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FILL) begin
				if (cnt_q == WIN_AW'(WIN_LEN - 1)) begin
					cnt_q     <= '0;
					ring_q    <= WIN_AW'(1);
					started_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (state_q == ST_PUSH) begin
				ring_q <= (ring_q == WIN_AW'(WIN_LEN - 1)) ? '0 : ring_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign report.valid              = out_valid_q;
	assign report.supply_efficiency  = in_eff_q;
	assign report.exhaust_efficiency = out_eff_q;
	assign report.in_filtered        = in_filt_q;
	assign report.out_filtered       = out_filt_q;
	assign report.zero_span          = zero_span_q;

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_in == done_out)
		else $error("ratio units out of step");

	a_fill_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> !started_q)
		else $error("window sweep after first transaction");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || report.ready))
		else $error("pending result overwritten");

	a_eff_range: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid |-> (report.in_filtered <= EFF_FULL_V
			&& report.out_filtered <= EFF_FULL_V
			&& report.supply_efficiency <= EFF_FULL_V
			&& report.exhaust_efficiency <= EFF_FULL_V))
		else $error("efficiency above full scale");

endmodule
